[hw/rtl/rdl_pkg.sv]
// Shared types, sizes and helpers for the region deduplication lookup unit.
package rdl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 40;
    localparam int ENTRY_IDX_W   = 10;
    localparam int SLOT_W        = 15;

    typedef enum logic [1:0] {
        OUT_FOUND    = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_FULL     = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_scan_state;

    typedef struct packed {
        logic [7:0]        tile_number;
        logic [7:0]        left_edge;
        logic [7:0]        right_edge;
        logic [7:0]        top_edge;
        logic [7:0]        bottom_edge;
        logic [SLOT_W-1:0] reference_slot;
    } t_in_req;

    typedef struct packed {
        logic [ENTRY_IDX_W-1:0] entry_index;
        t_outcome               outcome;
        logic [SLOT_W-1:0]      echoed_slot;
    } t_out_req;

    // Result handed from the scan engine to the output register.
    typedef struct packed {
        logic     valid;
        t_out_req data;
    } t_res_if;

    // Stored key layout: bottom, top, right, left, tile from high to low bits.
    function automatic logic [KEY_W-1:0] pack_key(input t_in_req req);
        return {req.bottom_edge, req.top_edge, req.right_edge,
                req.left_edge, req.tile_number};
    endfunction

    // The result field carries the low bits of the table index.
    function automatic logic [ENTRY_IDX_W-1:0] to_entry_index(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[ENTRY_IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/rdl_scan.sv]
// Scan engine: holds the region memory, walks it in order and appends on a miss while there is room.
module rdl_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  rdl_pkg::t_in_req i_req,
    output rdl_pkg::t_res_if o_res,
    input  logic            i_res_take
);

    logic [rdl_pkg::KEY_W-1:0] r_mem [rdl_pkg::TABLE_ENTRIES];

    rdl_pkg::t_scan_state        r_state, n_state;
    logic [rdl_pkg::KEY_W-1:0]   r_key;
    logic [rdl_pkg::SLOT_W-1:0]  r_slot;
    logic [rdl_pkg::CNT_W-1:0]   r_issue;
    logic [rdl_pkg::CNT_W-1:0]   r_count;
    logic                        r_pend;
    logic [rdl_pkg::IDX_W-1:0]   r_pend_idx;
    logic [rdl_pkg::KEY_W-1:0]   r_rd_data;
    rdl_pkg::t_out_req           r_res;

    logic accept;
    logic hit;
    logic scan_end;
    logic rd_en;
    logic wr_en;
    logic has_room;

    assign accept   = i_req_valid && !o_req_stall;
    assign hit      = (r_state == rdl_pkg::S_SCAN) && r_pend && (r_rd_data == r_key);
    // Every stored entry has been read and compared without a match.
    assign scan_end = (r_state == rdl_pkg::S_SCAN) && !r_pend && (r_issue >= r_count);
    assign has_room = r_count < rdl_pkg::CNT_W'(rdl_pkg::TABLE_ENTRIES);
    assign wr_en    = scan_end && has_room;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdl_pkg::S_IDLE: begin
                if (i_req_valid) n_state = rdl_pkg::S_SCAN;
            end
            rdl_pkg::S_SCAN: begin
                if (hit || scan_end) n_state = rdl_pkg::S_DONE;
            end
            rdl_pkg::S_DONE: begin
                if (i_res_take) n_state = rdl_pkg::S_IDLE;
            end
            default: n_state = rdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_stall = (r_state != rdl_pkg::S_IDLE);
        o_res.valid = (r_state == rdl_pkg::S_DONE);
        o_res.data  = r_res;
        rd_en       = (r_state == rdl_pkg::S_SCAN) && (r_issue < r_count) && !hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdl_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pend <= 1'b0;
            end else begin
                r_pend <= rd_en;
            end
            if (wr_en) r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key   <= rdl_pkg::pack_key(i_req);
            r_slot  <= i_req.reference_slot;
            r_issue <= '0;
        end else if (rd_en) begin
            r_issue <= r_issue + 1'b1;
        end
        if (rd_en) r_pend_idx <= r_issue[rdl_pkg::IDX_W-1:0];
        if (hit) begin
            r_res.entry_index <= rdl_pkg::to_entry_index(r_pend_idx);
            r_res.outcome     <= rdl_pkg::OUT_FOUND;
            r_res.echoed_slot <= r_slot;
        end else if (scan_end) begin
            r_res.echoed_slot <= r_slot;
            if (has_room) begin
                r_res.entry_index <= rdl_pkg::to_entry_index(r_count[rdl_pkg::IDX_W-1:0]);
                r_res.outcome     <= rdl_pkg::OUT_INSERTED;
            end else begin
                r_res.entry_index <= '0;
                r_res.outcome     <= rdl_pkg::OUT_FULL;
            end
        end
    end

    // Reads stay below the fill count and the single write lands at it,
    // so a read and a write never touch the same entry in one request.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_count[rdl_pkg::IDX_W-1:0]] <= r_key;
        if (rd_en) r_rd_data <= r_mem[r_issue[rdl_pkg::IDX_W-1:0]];
    end

endmodule

[hw/rtl/region_dedup_lookup_insert_unit.sv]
// Top level of the region deduplication unit: scan engine plus output register.
// A request reads the stored entries in order, one memory read per cycle, comparing each with
// its key; the result is registered in the engine and then handed to the output register.
// One request is in work at a time; the next is taken in the cycle after the result is handed
// to the output register.
// Reset is synchronous and active low; it empties the table and the output.
module region_dedup_lookup_insert_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rdl_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rdl_pkg::t_out_req o_out_req
);

    rdl_pkg::t_res_if  res;
    logic              res_take;
    logic              r_out_valid;
    rdl_pkg::t_out_req r_out_req;

    rdl_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_stall (o_in_stall),
        .i_req       (i_in_req),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // The output register frees the engine while a result waits downstream.
    assign res_take = res.valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) r_out_req <= res.data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

[hw/rtl/rdl_checker.sv]
// Port-level checker for the region deduplication unit, bound to the top level.
module rdl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input rdl_pkg::t_out_req o_out_req
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    // A full table reports index zero.
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.outcome == rdl_pkg::OUT_FULL)
            |-> (o_out_req.entry_index == '0))
        else $error("full outcome with nonzero index");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while scanning");

endmodule

bind region_dedup_lookup_insert_unit rdl_checker u_rdl_checker (.*);
